>>> hw/rtl/ctst_pkg.sv
// Shared types, codes and constants of the core table scanner.
package ctst_pkg;

	localparam int MAX_WORDS_DEF = 128;
	localparam int QUEUE_DEPTH   = 2;

	localparam int CFG_W     = 12;
	localparam int CFG_IDX_W = 2;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_ARM = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SECOND_ARM   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_THIRD_ARM    = 2'd2;

	localparam logic [CFG_W-1:0] EXPECTED_ARM_RST = 12'd2090;
	localparam logic [CFG_W-1:0] SECOND_ARM_RST   = 12'd2085;
	localparam logic [CFG_W-1:0] THIRD_ARM_RST    = 12'd2110;

	// Word types as they appear in bits 3:0 of a table word
	localparam logic [3:0] WTYPE_CORE = 4'h1;
	localparam logic [3:0] WTYPE_ADDR = 4'h5;
	localparam logic [3:0] WTYPE_END  = 4'hF;

	// Core ids with a fixed meaning
	localparam logic [11:0] CORE_COMMON = 12'h800;
	localparam logic [11:0] CORE_RAM    = 12'h80E;
	localparam logic [11:0] CORE_SDIO   = 12'h829;
	localparam logic [11:0] CORE_RADIO  = 12'h812;

	// Slot codes
	localparam logic [2:0] SLOT_NONE     = 3'd0;
	localparam logic [2:0] SLOT_COMMON   = 3'd1;
	localparam logic [2:0] SLOT_ARMCTL   = 3'd2;
	localparam logic [2:0] SLOT_ARMREGS  = 3'd3;
	localparam logic [2:0] SLOT_RAMCTL   = 3'd4;
	localparam logic [2:0] SLOT_RAMREGS  = 3'd5;
	localparam logic [2:0] SLOT_SDREGS   = 3'd6;
	localparam logic [2:0] SLOT_RADIOCTL = 3'd7;

	// Revision targets
	localparam logic [1:0] REV_NONE = 2'd0;
	localparam logic [1:0] REV_RAM  = 2'd1;
	localparam logic [1:0] REV_SDIO = 2'd2;

	// Bits of the first-wins flags
	localparam int FW_ARMCTL  = 0;
	localparam int FW_ARMREGS = 1;
	localparam int FW_RAMREGS = 2;

	typedef enum logic [1:0] {
		KIND_OTHER,
		KIND_CORE,
		KIND_ADDR,
		KIND_END
	} kind_t;

	typedef struct packed {
		logic [31:0] table_word;
		logic        scan_start;
	} item_t;

	typedef struct packed {
		logic [2:0]  slot_code;
		logic [31:0] slot_address;
		logic [1:0]  rev_target;
		logic [11:0] record_core_id;
		logic [7:0]  record_core_rev;
		logic        scan_finished;
		logic        arm_as_expected;
	} result_t;

	// Classified word as it sits in the queue
	typedef struct packed {
		kind_t       kind;
		logic        ctl;
		logic [19:0] addr_hi;
		logic [11:0] core_id;
		logic [7:0]  core_rev;
		logic        start;
	} cmd_t;

endpackage

>>> hw/rtl/ctst_front.sv
// Front end: takes table words and classifies them for the queue.
module ctst_front import ctst_pkg::*; (
	input  logic  item_valid,
	output logic  item_stall,
	input  item_t item,
	input  logic  queue_full,
	output logic  push,
	output cmd_t  push_cmd
);

	kind_t kind;

	always_comb begin
		case (item.table_word[3:0])
			WTYPE_CORE: kind = KIND_CORE;
			WTYPE_ADDR: kind = KIND_ADDR;
			WTYPE_END:  kind = KIND_END;
			default:    kind = KIND_OTHER;
		endcase
	end

	assign item_stall = queue_full;
	assign push       = item_valid && !queue_full;

	always_comb begin
		push_cmd.kind     = kind;
		push_cmd.ctl      = |item.table_word[7:6];
		push_cmd.addr_hi  = item.table_word[31:12];
		push_cmd.core_id  = item.table_word[19:8];
		push_cmd.core_rev = item.table_word[31:24];
		push_cmd.start    = item.scan_start;
	end

endmodule

>>> hw/rtl/ctst_queue.sv
// Short queue of classified words between front and back end.
module ctst_queue import ctst_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic nonempty,
	output cmd_t head
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		ptr_next = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign nonempty = (count_q != '0);
	assign head     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> hw/rtl/ctst_back.sv
// Back end: scan state, slot assignment, configuration and result register.
module ctst_back import ctst_pkg::*; #(
	parameter int MAX_WORDS = MAX_WORDS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 queue_nonempty,
	input  cmd_t                 head,
	output logic                 pop,
	output logic                 result_valid,
	input  logic                 result_stall,
	output result_t              result
);

	localparam int CW = $clog2(MAX_WORDS + 1);

	logic [CFG_W-1:0] exp_id_q, second_id_q, third_id_q;

	logic          stopped_q, pend_valid_q;
	logic [CW-1:0] seen_q;
	logic [11:0]   pend_id_q, cur_id_q, arm_seen_q;
	logic [7:0]    cur_rev_q;
	logic [2:0]    flags_q;

	logic          stopped_d, pend_valid_d;
	logic [CW-1:0] seen_d;
	logic [11:0]   pend_id_d, cur_id_d, arm_seen_d;
	logic [7:0]    cur_rev_d;
	logic [2:0]    flags_d;
	logic [2:0]    slot;
	logic [1:0]    rev;
	logic [31:0]   addr;
	logic          is_arm;

	result_t res_q;
	logic    res_valid_q;

	assign pop          = queue_nonempty && (!res_valid_q || !result_stall);
	assign result_valid = res_valid_q;
	assign result       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_id_q    <= EXPECTED_ARM_RST;
			second_id_q <= SECOND_ARM_RST;
			third_id_q  <= THIRD_ARM_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_EXPECTED_ARM: exp_id_q    <= cfg_data;
				CFG_SECOND_ARM:   second_id_q <= cfg_data;
				CFG_THIRD_ARM:    third_id_q  <= cfg_data;
				default:          ;
			endcase
		end
	end

	always_comb begin
		// Start from cleared state when this word opens a new scan
		if (head.start) begin
			stopped_d    = 1'b0;
			seen_d       = '0;
			pend_valid_d = 1'b0;
			pend_id_d    = '0;
			cur_id_d     = '0;
			cur_rev_d    = '0;
			arm_seen_d   = '0;
			flags_d      = '0;
		end else begin
			stopped_d    = stopped_q;
			seen_d       = seen_q;
			pend_valid_d = pend_valid_q;
			pend_id_d    = pend_id_q;
			cur_id_d     = cur_id_q;
			cur_rev_d    = cur_rev_q;
			arm_seen_d   = arm_seen_q;
			flags_d      = flags_q;
		end
		slot   = SLOT_NONE;
		rev    = REV_NONE;
		addr   = '0;
		is_arm = (cur_id_d == exp_id_q) || (cur_id_d == second_id_q) ||
			(cur_id_d == third_id_q);

		if (!stopped_d && (seen_d < CW'(MAX_WORDS))) begin
			seen_d = seen_d + CW'(1);
			if (pend_valid_d && head.kind == KIND_CORE) begin
				cur_id_d     = pend_id_d;
				cur_rev_d    = head.core_rev;
				pend_valid_d = 1'b0;
			end else begin
				pend_valid_d = 1'b0;
				case (head.kind)
					KIND_END: stopped_d = 1'b1;
					KIND_CORE: begin
						pend_valid_d = 1'b1;
						pend_id_d    = head.core_id;
					end
					KIND_ADDR: begin
						if (cur_id_d == CORE_COMMON) begin
							if (!head.ctl) slot = SLOT_COMMON;
						end else if (is_arm) begin
							arm_seen_d = cur_id_d;
							if (head.ctl) begin
								if (!flags_d[FW_ARMCTL]) begin
									slot = SLOT_ARMCTL;
									if (head.addr_hi != '0) flags_d[FW_ARMCTL] = 1'b1;
								end
							end else if (!flags_d[FW_ARMREGS]) begin
								slot = SLOT_ARMREGS;
								if (head.addr_hi != '0) flags_d[FW_ARMREGS] = 1'b1;
							end
						end else if (cur_id_d == CORE_RAM) begin
							rev = REV_RAM;
							if (head.ctl) begin
								slot = SLOT_RAMCTL;
							end else if (!flags_d[FW_RAMREGS]) begin
								slot = SLOT_RAMREGS;
								if (head.addr_hi != '0) flags_d[FW_RAMREGS] = 1'b1;
							end
						end else if (cur_id_d == CORE_SDIO) begin
							rev = REV_SDIO;
							if (!head.ctl) slot = SLOT_SDREGS;
						end else if (cur_id_d == CORE_RADIO) begin
							if (head.ctl) slot = SLOT_RADIOCTL;
						end
						if (slot != SLOT_NONE) addr = {head.addr_hi, 12'h000};
					end
					default: ;
				endcase
			end
			// Stop at the word limit and drop a half-read core pair
			if (seen_d >= CW'(MAX_WORDS)) begin
				stopped_d    = 1'b1;
				pend_valid_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stopped_q    <= 1'b0;
			seen_q       <= '0;
			pend_valid_q <= 1'b0;
			pend_id_q    <= '0;
			cur_id_q     <= '0;
			cur_rev_q    <= '0;
			arm_seen_q   <= '0;
			flags_q      <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if (pop) begin
				stopped_q    <= stopped_d;
				seen_q       <= seen_d;
				pend_valid_q <= pend_valid_d;
				pend_id_q    <= pend_id_d;
				cur_id_q     <= cur_id_d;
				cur_rev_q    <= cur_rev_d;
				arm_seen_q   <= arm_seen_d;
				flags_q      <= flags_d;
				res_valid_q  <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q.slot_code       <= slot;
			res_q.slot_address    <= addr;
			res_q.rev_target      <= rev;
			res_q.record_core_id  <= cur_id_d;
			res_q.record_core_rev <= cur_rev_d;
			res_q.scan_finished   <= stopped_d;
			res_q.arm_as_expected <= (arm_seen_d == exp_id_q);
		end
	end

endmodule

>>> hw/rtl/core_table_scanner.sv
// Top level of the core table scanner.
//
// Takes one enumeration table word per cycle while item_stall is low and
// returns exactly one result per word, in order. Each item goes through a
// combinational classifier into a two-entry queue; the back end pops one
// queued word per cycle unless the result side stalls, updates the scan
// state and loads the result register, so the sustained rate is one word per
// clock. The queue absorbs a result stall for up to two words before item_stall
// rises. The user must write the ARM core ids through the plain configuration
// port only while no word is in flight; the block itself does not enforce this.
module core_table_scanner import ctst_pkg::*; #(
	parameter int MAX_WORDS = MAX_WORDS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  item_t                item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output result_t              result
);

	logic push, pop, queue_full, queue_nonempty;
	cmd_t push_cmd, head;

	ctst_front u_front (
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.queue_full (queue_full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	ctst_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (queue_full),
		.pop      (pop),
		.nonempty (queue_nonempty),
		.head     (head)
	);

	ctst_back #(
		.MAX_WORDS (MAX_WORDS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.queue_nonempty (queue_nonempty),
		.head           (head),
		.pop            (pop),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.result         (result)
	);

endmodule

>>> hw/rtl/ctst_checker.sv
// Port-level checks of the core table scanner, bound to the top level.
module ctst_checker import ctst_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	// Hold a stalled result transaction
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed or dropped");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.slot_code == SLOT_NONE |-> result.slot_address == 32'h0)
		else $error("address given without a slot");

	a_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.slot_address[11:0] == 12'h000)
		else $error("slot address not 4 KiB aligned");

	// The word limit may stop the scan on an address word, so scan_finished is left open
	a_rev_slot: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.rev_target != REV_NONE |->
			(result.slot_code == SLOT_NONE || result.slot_code == SLOT_RAMCTL ||
			 result.slot_code == SLOT_RAMREGS || result.slot_code == SLOT_SDREGS))
		else $error("revision target with a foreign slot");

endmodule

bind core_table_scanner ctst_checker u_ctst_checker (.*);

>>> sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of the core table scanner: random table scans against a slot predictor.
module testbench;
	import ctst_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_WORDS = 50;

	// Predicts the slot record of every accepted table word and checks the records that come back
	class slot_scoreboard;
		logic [CFG_W-1:0] arm_expected;
		logic [CFG_W-1:0] arm_second;
		logic [CFG_W-1:0] arm_third;
		bit               stopped;
		int               word_count;
		bit               pair_open;
		logic [11:0]      pair_id;
		logic [11:0]      core_id;
		logic [7:0]       core_rev;
		logic [11:0]      arm_seen;
		logic [2:0]       taken;
		result_t          records[$];
		int               errors;

		function new();
			arm_expected = EXPECTED_ARM_RST;
			arm_second   = SECOND_ARM_RST;
			arm_third    = THIRD_ARM_RST;
			errors       = 0;
			clear_scan();
		endfunction

		function void clear_scan();
			stopped    = 1'b0;
			word_count = 0;
			pair_open  = 1'b0;
			pair_id    = '0;
			core_id    = '0;
			core_rev   = '0;
			arm_seen   = '0;
			taken      = '0;
		endfunction

		function void set_arm_id(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			case (idx)
				CFG_EXPECTED_ARM: arm_expected = val;
				CFG_SECOND_ARM:   arm_second = val;
				CFG_THIRD_ARM:    arm_third = val;
				default:          ;
			endcase
		endfunction

		function bit is_arm(logic [11:0] id);
			return id == arm_expected || id == arm_second || id == arm_third;
		endfunction

		// First nonzero address wins; a zero address leaves the slot open
		function logic [2:0] claim(int flag, logic [2:0] code, logic [31:0] a);
			if (taken[flag])
				return SLOT_NONE;
			if (a != 0)
				taken[flag] = 1'b1;
			return code;
		endfunction

		function void note_word(item_t it);
			result_t     r;
			logic [31:0] w;
			logic [31:0] a;
			logic        ctl;
			w   = it.table_word;
			a   = {w[31:12], 12'h000};
			ctl = |w[7:6];
			r   = '0;
			if (it.scan_start)
				clear_scan();
			if (!stopped && word_count < MAX_WORDS_DEF) begin
				word_count++;
				if (pair_open && w[3:0] == WTYPE_CORE) begin
					core_id   = pair_id;
					core_rev  = w[31:24];
					pair_open = 1'b0;
				end else begin
					pair_open = 1'b0;
					if (w[3:0] == WTYPE_END) begin
						stopped = 1'b1;
					end else if (w[3:0] == WTYPE_CORE) begin
						pair_open = 1'b1;
						pair_id   = w[19:8];
					end else if (w[3:0] == WTYPE_ADDR) begin
						if (core_id == CORE_COMMON) begin
							if (!ctl)
								r.slot_code = SLOT_COMMON;
						end else if (is_arm(core_id)) begin
							arm_seen = core_id;
							if (ctl)
								r.slot_code = claim(FW_ARMCTL, SLOT_ARMCTL, a);
							else
								r.slot_code = claim(FW_ARMREGS, SLOT_ARMREGS, a);
						end else if (core_id == CORE_RAM) begin
							if (ctl)
								r.slot_code = SLOT_RAMCTL;
							else
								r.slot_code = claim(FW_RAMREGS, SLOT_RAMREGS, a);
							r.rev_target = REV_RAM;
						end else if (core_id == CORE_SDIO) begin
							if (!ctl)
								r.slot_code = SLOT_SDREGS;
							r.rev_target = REV_SDIO;
						end else if (core_id == CORE_RADIO && ctl) begin
							r.slot_code = SLOT_RADIOCTL;
						end
						if (r.slot_code != SLOT_NONE)
							r.slot_address = a;
					end
				end
				// drop a half pair at the word limit: nothing past the table end
				if (word_count >= MAX_WORDS_DEF) begin
					stopped   = 1'b1;
					pair_open = 1'b0;
				end
			end
			r.record_core_id  = core_id;
			r.record_core_rev = core_rev;
			r.scan_finished   = stopped;
			r.arm_as_expected = arm_seen == arm_expected;
			records.push_back(r);
		endfunction

		function void same(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected 'h%0h, actual 'h%0h", field, want, got);
				errors++;
			end
		endfunction

		function void check_record(result_t got);
			result_t want;
			if (records.size() == 0) begin
				$error("record returned with no table word outstanding");
				errors++;
				return;
			end
			want = records.pop_front();
			same("slot_code", want.slot_code, got.slot_code);
			same("slot_address", want.slot_address, got.slot_address);
			same("rev_target", want.rev_target, got.rev_target);
			same("record_core_id", want.record_core_id, got.record_core_id);
			same("record_core_rev", want.record_core_rev, got.record_core_rev);
			same("scan_finished", want.scan_finished, got.scan_finished);
			same("arm_as_expected", want.arm_as_expected, got.arm_as_expected);
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 item_valid;
	logic                 item_stall;
	item_t                item;
	logic                 result_valid;
	logic                 result_stall;
	result_t              result;

	slot_scoreboard   board;
	logic [CFG_W-1:0] arm_ids [3];
	bit               fresh_scan;
	bit               rev_due;
	int               addr_left;
	int               phase_words;
	int               send_gap_pct;
	int               stall_pct;
	int               restart_pct;
	int               cycles;

	core_table_scanner uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk)
		result_stall <= $urandom_range(99) < stall_pct;

	always @(posedge clk) begin
		if (arst_n && item_valid && !item_stall)
			board.note_word(item);
		if (arst_n && result_valid && !result_stall)
			board.check_record(result);
	end

	function automatic logic [31:0] typed_word(logic [3:0] wtype);
		logic [31:0] w;
		w = $urandom;
		w[3:0] = wtype;
		return w;
	endfunction

	function automatic logic [31:0] core_word(logic [11:0] id);
		logic [31:0] w;
		w = typed_word(WTYPE_CORE);
		w[19:8] = id;
		return w;
	endfunction

	function automatic logic [31:0] addr_word(bit ctl);
		logic [31:0] w;
		w = typed_word(WTYPE_ADDR);
		if (!ctl)
			w[7:6] = 2'b00;
		else if (w[7:6] == 2'b00)
			w[7:6] = 2'($urandom_range(3, 1));
		if ($urandom_range(7) == 0)
			w[31:12] = '0;
		return w;
	endfunction

	function automatic logic [11:0] pick_core();
		case ($urandom_range(10))
			0:       return CORE_COMMON;
			1:       return CORE_RAM;
			2:       return CORE_SDIO;
			3:       return CORE_RADIO;
			4, 5:    return arm_ids[0];
			6:       return arm_ids[1];
			7:       return arm_ids[2];
			8:       return 12'($urandom);
			default: return 12'h000;
		endcase
	endfunction

	// Endless well-formed stream: core pairs followed by address words, with some noise
	function automatic logic [31:0] stream_word();
		if (rev_due) begin
			rev_due = 1'b0;
			return typed_word(WTYPE_CORE);
		end
		if (addr_left > 0) begin
			addr_left--;
			return addr_word($urandom_range(1));
		end
		case ($urandom_range(19))
			0: return $urandom;
			1: begin
				// half pair: the address word follows directly
				addr_left = $urandom_range(3, 1);
				return core_word(pick_core());
			end
			default: begin
				rev_due   = 1'b1;
				addr_left = $urandom_range(4, 1);
				return core_word(pick_core());
			end
		endcase
	endfunction

	task automatic put(logic [31:0] w);
		item_t it;
		it.table_word = w;
		it.scan_start = fresh_scan || $urandom_range(99) < restart_pct;
		fresh_scan = 1'b0;
		if ($urandom_range(99) < send_gap_pct) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall);
		phase_words++;
	endtask

	// Hold the sender until every record is back; let the last transaction be noted first
	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (board.records.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(logic [CFG_W-1:0] e, logic [CFG_W-1:0] s, logic [CFG_W-1:0] t);
		logic [CFG_W-1:0] vals [3];
		vals = '{e, s, t};
		for (int i = 0; i < 3; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data  <= vals[i];
			@(posedge clk);
			board.set_arm_id(CFG_IDX_W'(i), vals[i]);
			arm_ids[i] = vals[i];
		end
		// an index past the register list must change nothing
		cfg_index <= CFG_SPARE;
		cfg_data  <= CFG_W'($urandom);
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_scan(input bit fill);
		int n;
		fresh_scan = 1'b1;
		rev_due    = 1'b0;
		addr_left  = 0;
		n = fill ? MAX_WORDS_DEF - 1 : $urandom_range(24, 4);
		repeat (n) put(stream_word());
		if (fill)
			put(core_word(pick_core()));
		else if ($urandom_range(4) != 0)
			put(typed_word(WTYPE_END));
		repeat ($urandom_range(2)) put($urandom);
	endtask

	initial begin
		board        = new();
		arm_ids      = '{EXPECTED_ARM_RST, SECOND_ARM_RST, THIRD_ARM_RST};
		cycles       = 0;
		send_gap_pct = 6;
		stall_pct    = 66;
		restart_pct  = 0;
		arst_n       <= 1'b0;
		cfg_write    <= 1'b0;
		cfg_index    <= '0;
		cfg_data     <= '0;
		item_valid   <= 1'b0;
		item         <= '0;
		result_stall <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		fresh_scan = 1'b1;
		put(32'h0000_0000);
		put(core_word(CORE_COMMON));
		put(32'hFF00_0001);
		put(32'h1234_5005);
		put(32'h1234_50C5);
		put(core_word(arm_ids[0]));
		put(32'h0000_0001);
		put(32'hFFFF_F045);
		put(32'h0001_0085);
		put(32'h0000_0005);
		put(32'hABCD_E005);
		put(32'h1111_1005);
		put(core_word(CORE_RAM));
		put(32'h5A00_0001);
		put(32'h2222_20C5);
		put(32'h3333_3005);
		put(core_word(CORE_SDIO));
		put(32'hA500_0001);
		put(32'h4444_4045);
		put(32'h5555_5005);
		put(core_word(CORE_RADIO));
		put(32'h0100_0001);
		put(32'h6666_60C5);
		// half pair: the address stays with the radio core
		put(core_word(CORE_SDIO));
		put(32'h7777_7005);
		put(32'h0000_0003);
		put(32'hFFFF_FFFF);
		put(32'h8888_8005);

		for (int p = 0; p < 6; p++) begin
			drain();
			case (p)
				1: configure('0, '0, '0);
				2: configure('1, '1, '1);
				3: configure(CORE_RAM, CORE_COMMON, CFG_W'($urandom));
				4: configure(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
				5: configure(EXPECTED_ARM_RST, SECOND_ARM_RST, THIRD_ARM_RST);
				default: ;
			endcase
			case (p % 3)
				0: begin
					send_gap_pct = 6;
					stall_pct    = 66;
				end
				1: begin
					send_gap_pct = 66;
					stall_pct    = 6;
				end
				default: begin
					send_gap_pct = 0;
					stall_pct    = 0;
				end
			endcase
			phase_words = 0;
			if (p == 5) begin
				restart_pct = 0;
				random_scan(1'b1);
			end
			restart_pct = 1;
			while (phase_words < PHASE_WORDS)
				random_scan(1'b0);
		end

		drain();
		repeat (8) @(posedge clk);
		if (board.errors == 0 && board.records.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
